[hw/rtl/y2r_pkg.sv]
// Shared types and constants for the YUYV to RGB converter.
// No dependencies; imported by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

    // Comparison width for row lengths: covers a stride register of 15 bits
    // and the largest supported row of 65536 bytes.
    localparam int CMP_W = 17;

    // One macropixel, ready for conversion.
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       row_end;
    } y2r_pair_t;

    // Status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } y2r_fifo_stat_t;

endpackage

`default_nettype wire

[hw/rtl/y2r_front.sv]
// Front end: row byte counter, byte classification and YUYV hold registers.
// Depends on y2r_pkg; pushes one macropixel per V byte into the queue.
`timescale 1ns / 1ps
`default_nettype none

module y2r_front #(
    parameter int MAX_ROW_BYTES = 16384
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [11:0]               macropixels_per_row,
    input  wire logic [14:0]               row_stride_bytes,
    input  wire logic                      in_valid,
    input  wire logic [7:0]                in_byte,
    output logic                           in_ready,
    input  wire y2r_pkg::y2r_fifo_stat_t   fifo_stat,
    output logic                           push,
    output y2r_pkg::y2r_pair_t             push_pair
);
    import y2r_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW_BYTES);
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_ROW_BYTES);

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       y0_reg, y0_next;
    logic [7:0]       u_reg, u_next;
    logic [7:0]       y1_reg, y1_next;

    logic [CMP_W-1:0] active_raw, stride_a, stride_b, stride_c, stride_eff;
    logic [CMP_W-1:0] stride_quad, active_eff, pos_ext, pos_inc;
    logic             in_active, is_v, accept;

    always_comb
    begin
        active_raw = CMP_W'({macropixels_per_row, 2'b00});
        stride_a   = CMP_W'(row_stride_bytes);
        stride_b   = (stride_a < active_raw) ? active_raw : stride_a;
        stride_c   = (stride_b > MAX_LEN) ? MAX_LEN : stride_b;
        stride_eff = (stride_c == '0) ? CMP_W'(1) : stride_c;
        stride_quad = {stride_eff[CMP_W-1:2], 2'b00};
        active_eff = (active_raw > stride_quad) ? stride_quad : active_raw;

        pos_ext   = CMP_W'(pos_reg);
        pos_inc   = pos_ext + CMP_W'(1);
        in_active = pos_ext < active_eff;
        is_v      = in_active && (pos_reg[1:0] == 2'b11);
    end

    // Stall only a V byte that finds the queue full.
    assign in_ready = !(is_v && fifo_stat.full);
    assign accept   = in_valid && in_ready;
    assign push     = accept && is_v;

    always_comb
    begin
        push_pair.luma_first  = y0_reg;
        push_pair.chroma_blue = u_reg;
        push_pair.luma_second = y1_reg;
        push_pair.chroma_red  = in_byte;
        push_pair.row_end     = (pos_inc == active_eff);
    end

    always_comb
    begin
        pos_next = pos_reg;
        y0_next  = y0_reg;
        u_next   = u_reg;
        y1_next  = y1_reg;
        if (accept)
        begin
            if (in_active)
            begin
                unique case (pos_reg[1:0])
                    2'b00:   y0_next = in_byte;
                    2'b01:   u_next  = in_byte;
                    2'b10:   y1_next = in_byte;
                    default: ;
                endcase
            end
            // Restart the row at the stride, or when a new config shortened it.
            if (pos_inc >= stride_eff)
                pos_next = '0;
            else
                pos_next = CNT_W'(pos_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            y0_reg  <= '0;
            u_reg   <= '0;
            y1_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            y0_reg  <= y0_next;
            u_reg   <= u_next;
            y1_reg  <= y1_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/y2r_fifo.sv]
// Two-entry queue of macropixels between the front and back ends.
// Depends on y2r_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module y2r_fifo (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire y2r_pkg::y2r_pair_t       push_pair,
    input  wire logic                     pop,
    output y2r_pkg::y2r_pair_t            pop_pair,
    output y2r_pkg::y2r_fifo_stat_t       stat
);
    import y2r_pkg::*;

    y2r_pair_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_pair   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_pair;
    end

endmodule

`default_nettype wire

[hw/rtl/y2r_back.sv]
// Back end: chroma products, then per-pixel floor shift, add or subtract, and clamp.
// Depends on y2r_pkg; pops macropixels from y2r_fifo, emits two pixels each.
`timescale 1ns / 1ps
`default_nettype none

module y2r_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire y2r_pkg::y2r_fifo_stat_t  fifo_stat,
    input  wire y2r_pkg::y2r_pair_t       pop_pair,
    output logic                          pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic                          out_second,
    output logic                          out_row_end
);
    import y2r_pkg::*;

    localparam int PROD_W = 26;
    localparam logic signed [PROD_W-1:0] COEF_RV = 26'sd37221;
    localparam logic signed [PROD_W-1:0] COEF_GU = 26'sd12975;
    localparam logic signed [PROD_W-1:0] COEF_GV = 26'sd18949;
    localparam logic signed [PROD_W-1:0] COEF_BU = 26'sd66883;

    function automatic logic [7:0] channel(input logic [7:0] y,
                                           input logic signed [PROD_W-1:0] p,
                                           input logic sub);
        logic signed [PROD_W-1:0] q;
        logic signed [11:0]       t;
        q = p >>> 15;
        if (sub)
            t = $signed({4'b0000, y}) - $signed(q[11:0]);
        else
            t = $signed({4'b0000, y}) + $signed(q[11:0]);
        if (t < 12'sd0)
            return 8'd0;
        else if (t > 12'sd255)
            return 8'd255;
        else
            return t[7:0];
    endfunction

    // Stage 1: products of one macropixel
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_sel_reg, s1_sel_next;
    logic [7:0]               s1_y0_reg, s1_y1_reg;
    logic                     s1_end_reg;
    logic signed [PROD_W-1:0] s1_pr_reg, s1_pg_reg, s1_pb_reg;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_r_reg, out_g_reg, out_b_reg;
    logic       out_second_reg, out_end_reg;

    logic signed [PROD_W-1:0] d_ext, e_ext;
    logic                     out_load, s1_done;
    logic [7:0]               sel_y;

    assign d_ext = PROD_W'($signed({~pop_pair.chroma_blue[7], pop_pair.chroma_blue[6:0]}));
    assign e_ext = PROD_W'($signed({~pop_pair.chroma_red[7], pop_pair.chroma_red[6:0]}));

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_done  = out_load && s1_sel_reg;
    assign pop      = !fifo_stat.empty && (!s1_valid_reg || s1_done);
    assign sel_y    = s1_sel_reg ? s1_y1_reg : s1_y0_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_sel_next   = s1_sel_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
            s1_sel_next   = 1'b0;
        end
        else if (s1_done)
            s1_valid_next = 1'b0;
        else if (out_load)
            s1_sel_next = 1'b1;

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_sel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_sel_reg    <= s1_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_y0_reg  <= pop_pair.luma_first;
            s1_y1_reg  <= pop_pair.luma_second;
            s1_end_reg <= pop_pair.row_end;
            s1_pr_reg  <= e_ext * COEF_RV;
            s1_pg_reg  <= d_ext * COEF_GU + e_ext * COEF_GV;
            s1_pb_reg  <= d_ext * COEF_BU;
        end
        if (out_load)
        begin
            out_r_reg      <= channel(sel_y, s1_pr_reg, 1'b0);
            out_g_reg      <= channel(sel_y, s1_pg_reg, 1'b1);
            out_b_reg      <= channel(sel_y, s1_pb_reg, 1'b0);
            out_second_reg <= s1_sel_reg;
            out_end_reg    <= s1_sel_reg && s1_end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_red     = out_r_reg;
    assign out_green   = out_g_reg;
    assign out_blue    = out_b_reg;
    assign out_second  = out_second_reg;
    assign out_row_end = out_end_reg;

endmodule

`default_nettype wire

[hw/rtl/yuyv_to_rgb_converter_core.sv]
// Top level of the YUYV 4:2:2 to RGB888 stream converter.
// Depends on y2r_pkg, y2r_front, y2r_fifo and y2r_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Word                     | Notes
// ----------+-----+--------------------------+-----------------------------------
// s_axis    | in  | tdata[7:0] data_byte     | one raster byte per word
// m_axis    | out | tdata red/green/blue     | tlast = second_of_pair
//           |     |                          | tuser[0] = row_end
// apb       | in  | reg 0 at 0x0, reg 1 at 0x4 | macropixels, row stride
//
// Rate: one byte word per cycle is accepted while s_axis_tready is high; each
// V byte yields two pixel words via the queue, stage-1 and output registers.
// Unstalled, the back end sustains one pixel per cycle, keeping up with a pair per
// four bytes. Reset: asynchronous, clears counters and queue; no clearing
// pass. Stalls: s_axis_tready drops only for a V byte while the two-entry
// queue is full, so output backpressure reaches the input after a few words.

module yuyv_to_rgb_converter_core #(
    parameter int MAX_ROW_BYTES = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic             m_axis_tlast,   // second_of_pair
    output logic [0:0]       m_axis_tuser,   // [0] row_end
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import y2r_pkg::*;

    localparam int REG_MPR    = 0;
    localparam int REG_STRIDE = 1;

    // Configuration registers
    logic [11:0] mpr_reg, mpr_next;
    logic [14:0] stride_reg, stride_next;
    logic        cfg_write;

    // Front/back links
    y2r_fifo_stat_t fifo_stat;
    y2r_pair_t      push_pair, pop_pair;
    logic           push, pop;

    logic [7:0] px_red, px_green, px_blue;
    logic       px_second, px_row_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Decode on the word address; low byte-offset bits are ignored.
    always_comb
    begin
        mpr_next    = mpr_reg;
        stride_next = stride_reg;
        if (cfg_write)
        begin
            unique case (32'(paddr[2]))
                REG_MPR:    mpr_next    = pwdata[11:0];
                REG_STRIDE: stride_next = pwdata[14:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (32'(paddr[2]))
            REG_MPR:    prdata = 32'(mpr_reg);
            REG_STRIDE: prdata = 32'(stride_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpr_reg    <= 12'd320;
            stride_reg <= 15'd1280;
        end
        else
        begin
            mpr_reg    <= mpr_next;
            stride_reg <= stride_next;
        end
    end

    // Classify bytes and hold Y0, U, Y1 until the V byte.
    y2r_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .macropixels_per_row (mpr_reg),
        .row_stride_bytes    (stride_reg),
        .in_valid            (s_axis_tvalid),
        .in_byte             (s_axis_tdata),
        .in_ready            (s_axis_tready),
        .fifo_stat           (fifo_stat),
        .push                (push),
        .push_pair           (push_pair)
    );

    // Decouple the byte side from the pixel side.
    y2r_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pair (push_pair),
        .pop       (pop),
        .pop_pair  (pop_pair),
        .stat      (fifo_stat)
    );

    // Convert each macropixel into two pixel words.
    y2r_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_stat   (fifo_stat),
        .pop_pair    (pop_pair),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_red     (px_red),
        .out_green   (px_green),
        .out_blue    (px_blue),
        .out_second  (px_second),
        .out_row_end (px_row_end)
    );

    assign m_axis_tdata = {px_blue, px_green, px_red};
    assign m_axis_tlast = px_second;
    assign m_axis_tuser = px_row_end;

    // Never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_stat.full)
        else $error("queue push while full");

    // The input stalls only on a full queue.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> fifo_stat.full)
        else $error("input stalled without full queue");

    // The second pixel of a pair follows the first right away.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tlast))
        else $error("second pixel did not follow the first");

    // Row end marks only the second pixel of a pair.
    a_row_end_second: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("row end on first pixel of a pair");

endmodule

`default_nettype wire
